@@ hw/rtl/mvt_pkg.sv @@
// Shared types and constants for the 4x4 matrix-vector transform.
// Depends on nothing; every other file imports it.
package mvt_pkg;

  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned PROD_WIDTH    = 2 * VALUE_WIDTH;
  localparam int unsigned SUM_WIDTH     = PROD_WIDTH + 2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  // Diagonal reset value: one in fixed point, or the largest value if one
  // cannot be represented.
  localparam value_t VALUE_ONE = (FRACTION_BITS >= VALUE_WIDTH - 1) ? VALUE_MAX :
                                 value_t'(64'd1 << FRACTION_BITS);

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSFORM = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [1:0] column;
    logic [1:0] row;
    value_t     element_value;
    value_t     vec_x;
    value_t     vec_y;
    value_t     vec_z;
    value_t     vec_w;
  } in_t;

  typedef struct packed {
    value_t out_x;
    value_t out_y;
    value_t out_z;
    value_t out_w;
    logic   saturated;
  } out_t;

  // Classified word as it sits in the queue between front and back.
  typedef struct packed {
    op_e                   kind;
    logic [3:0]            addr;   // column * 4 + row
    value_t                value;
    logic [3:0][VALUE_WIDTH-1:0] vec;
  } entry_t;

  // Sixteen products, indexed [row][column].
  typedef logic [3:0][3:0][PROD_WIDTH-1:0] prod_blk_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

@@ hw/rtl/mvt_front.sv @@
// Front end: accepts input words, classifies them and holds them in a
// two-entry queue for the back end. Depends on mvt_pkg.
module mvt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mvt_pkg::in_t         item_i,
  output logic                 full_o,
  output mvt_pkg::queue_head_t head_o,
  input  logic                 take_i
);
  import mvt_pkg::*;

  entry_t     mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push_ok, pop_ok;
  entry_t     entry_in;

  assign full_o  = (count_q == 2'd2);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = take_i && (count_q != 2'd0);

  // Classify: writes keep the address and value, transforms the vector.
  always_comb begin
    entry_in.kind   = item_i.operation;
    entry_in.addr   = {item_i.column, item_i.row};
    entry_in.value  = item_i.element_value;
    entry_in.vec[0] = item_i.vec_x;
    entry_in.vec[1] = item_i.vec_y;
    entry_in.vec[2] = item_i.vec_z;
    entry_in.vec[3] = item_i.vec_w;
  end

  always_comb begin
    count_d = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= entry_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

@@ hw/rtl/mvt_mul.sv @@
// Back end, first stage: owns the matrix, applies writes in order and
// forms the sixteen products of a transform. Depends on mvt_pkg.
module mvt_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mvt_pkg::queue_head_t head_i,
  output logic                 take_o,
  output logic                 prod_valid_o,
  output mvt_pkg::prod_blk_t   prod_o,
  input  logic                 prod_ready_i
);
  import mvt_pkg::*;

  value_t    mat_q [16];
  prod_blk_t prod_q, prod_d;
  logic      valid_q;
  logic      stage_free;
  logic      is_write;
  logic      do_write, do_xform;

  assign stage_free = !valid_q || prod_ready_i;
  assign is_write   = (head_i.entry.kind == OP_WRITE);
  // Writes retire here and never wait on the pipeline.
  assign take_o     = head_i.valid && (is_write || stage_free);
  assign do_write   = take_o && is_write;
  assign do_xform   = take_o && !is_write;

  always_comb begin
    value_t m;
    value_t v;
    prod_t  p;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m = mat_q[c*4 + r];
        v = value_t'(head_i.entry.vec[c]);
        p = prod_t'(m) * prod_t'(v);
        prod_d[r][c] = p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= ((i % 5) == 0) ? VALUE_ONE : '0;
      end
    end else if (do_write) begin
      mat_q[head_i.entry.addr] <= head_i.entry.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stage_free) begin
      valid_q <= do_xform;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_xform) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = valid_q;
  assign prod_o       = prod_q;

endmodule

@@ hw/rtl/mvt_sum.sv @@
// Back end, last stages: adds the products of each row in two steps,
// scales, saturates and holds the result word. Depends on mvt_pkg.
module mvt_sum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               prod_valid_i,
  input  mvt_pkg::prod_blk_t prod_i,
  output logic               prod_ready_o,
  output logic               empty_o,
  output mvt_pkg::out_t      result_o,
  input  logic               pop_i
);
  import mvt_pkg::*;

  typedef logic signed [PROD_WIDTH:0] pair_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;

  pair_t  pair_q [4][2];
  pair_t  pair_d [4][2];
  logic   pair_valid_q;
  out_t   res_q, res_d;
  logic   res_valid_q;
  logic   res_free, pair_free;
  value_t comp [4];
  logic   comp_sat [4];

  assign res_free     = !res_valid_q || pop_i;
  assign pair_free    = !pair_valid_q || res_free;
  assign prod_ready_o = pair_free;

  always_comb begin
    prod_t a;
    prod_t b;
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        a = prod_t'(prod_i[r][2*h]);
        b = prod_t'(prod_i[r][2*h+1]);
        pair_d[r][h] = {a[PROD_WIDTH-1], a} + {b[PROD_WIDTH-1], b};
      end
    end
  end

  // Full sum, arithmetic shift, then clip to the value range.
  always_comb begin
    sum_t total;
    sum_t scaled;
    logic all_ones;
    logic all_zeros;
    for (int r = 0; r < 4; r++) begin
      total     = {pair_q[r][0][PROD_WIDTH], pair_q[r][0]} +
                  {pair_q[r][1][PROD_WIDTH], pair_q[r][1]};
      scaled    = total >>> FRACTION_BITS;
      all_ones  = &scaled[SUM_WIDTH-1:VALUE_WIDTH-1];
      all_zeros = ~|scaled[SUM_WIDTH-1:VALUE_WIDTH-1];
      if (scaled[SUM_WIDTH-1] && !all_ones) begin
        comp[r]     = VALUE_MIN;
        comp_sat[r] = 1'b1;
      end else if (!scaled[SUM_WIDTH-1] && !all_zeros) begin
        comp[r]     = VALUE_MAX;
        comp_sat[r] = 1'b1;
      end else begin
        comp[r]     = scaled[VALUE_WIDTH-1:0];
        comp_sat[r] = 1'b0;
      end
    end
    res_d.out_x     = comp[0];
    res_d.out_y     = comp[1];
    res_d.out_z     = comp[2];
    res_d.out_w     = comp[3];
    res_d.saturated = comp_sat[0] | comp_sat[1] | comp_sat[2] | comp_sat[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (pair_free) begin
        pair_valid_q <= prod_valid_i;
      end
      if (res_free) begin
        res_valid_q <= pair_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_free && prod_valid_i) begin
      pair_q <= pair_d;
    end
    if (res_free && pair_valid_q) begin
      res_q <= res_d;
    end
  end

  assign empty_o  = !res_valid_q;
  assign result_o = res_q;

endmodule

@@ hw/rtl/matrix_vector_transform_4x4.sv @@
// Top level of the 4x4 matrix-vector transform.
// Depends on mvt_pkg, mvt_front, mvt_mul and mvt_sum.
//
// The block holds a column-major 4x4 matrix of signed Q16.16 values, the
// identity after reset, and takes one input word per cycle through a
// push/full port. A write word stores element_value at (column, row) and
// gives no result; a transform word gives one result word with each
// component the dot product of a matrix row with (x, y, z, w): the four
// full-precision products are summed, shifted right arithmetically by the
// fraction bits and clipped to 32 bits, with saturated set when any
// component clips. Results leave through an empty/pop port in input order.
// Words are accepted every cycle while full is low; a transform word's
// result passes from the queue slot through the product register, the
// pair-sum register and the result register. The sustained rate of one
// word per cycle, while results are popped, is set by the sixteen parallel
// 32x32 multipliers of the product stage. A two-entry queue between the
// front end and the matrix takes input while the result port stalls, until
// it fills, and each pipeline stage advances as soon as the one after it
// frees up.
module matrix_vector_transform_4x4 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mvt_pkg::in_t  item_i,
  output logic          full_o,
  output logic          empty_o,
  output mvt_pkg::out_t result_o,
  input  logic          pop_i
);
  import mvt_pkg::*;

  queue_head_t head;
  logic        take;
  logic        prod_valid;
  logic        prod_ready;
  prod_blk_t   prod;

  // Accept and classify incoming words.
  mvt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .item_i (item_i),
    .full_o (full_o),
    .head_o (head),
    .take_i (take)
  );

  // Apply writes, form products of transforms.
  mvt_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .take_o       (take),
    .prod_valid_o (prod_valid),
    .prod_o       (prod),
    .prod_ready_i (prod_ready)
  );

  // Sum, scale, clip and hold the result word.
  mvt_sum u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .prod_ready_o (prod_ready),
    .empty_o      (empty_o),
    .result_o     (result_o),
    .pop_i        (pop_i)
  );

endmodule
